[src/gfa_pkg.sv]
package gfa_pkg;

  localparam logic [63:0] FieldP   = 64'hffffffff00000001;
  localparam logic [63:0] HalfPUp  = 64'h7fffffff80000001;
  localparam logic [63:0] Low32    = 64'h00000000ffffffff;

  typedef enum logic [2:0] {
    KindAdd    = 3'd0,
    KindSub    = 3'd1,
    KindNeg    = 3'd2,
    KindMulAdd = 3'd3,
    KindDiv    = 3'd4,
    KindPow    = 3'd5
  } kind_e;

  // field subtract with wrap correction
  function automatic logic [63:0] f_sub(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] z;
    z = x - y;
    return (z > x) ? (z + FieldP) : z;
  endfunction

  // fold a 128-bit value into the field
  function automatic logic [63:0] f_fold(input logic [63:0] hi, input logic [63:0] lo);
    logic [63:0] n1, n2, mid, t, r;
    n1  = hi & Low32;
    n2  = hi >> 32;
    mid = (n1 << 32) - n1;
    t   = lo + mid;
    if (t < lo) t = t - FieldP;
    r = t - n2;
    if (r > t) r = r + FieldP;
    return (r >= FieldP) ? (r - FieldP) : r;
  endfunction

endpackage

[src/goldilocks_field_alu.sv]
// goldilocks field alu, one item in the sequencer at a time
// add/sub/neg compute on accept, multiply-add sums partial products then folds
// divide: halving steps and subtract steps until u or v reaches one
// power: optional inversion, then square-and-multiply through the shared multiplier
// throughput: next word accepted once the previous result is in the output register
// reset: asynchronous active low, clears the sequencer and output valid
module goldilocks_field_alu (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: operand_a[63:0], operand_b[127:64], addend[191:128], exponent[223:192]
  input  logic [223:0] s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: value[63:0], fault[64], zero fill
  output logic [71:0]  m_axis_tdata
);

  typedef enum logic [3:0] {
    StIdle, StDivOdd, StDivSub, StMul, StMulFold, StPowStep, StDone
  } state_e;

  state_e      state_q;
  logic [2:0]  kind_q;
  logic [63:0] x_q, y_q, u_q, v_q;
  logic [63:0] sq_q, acc_q, c_q;
  logic [31:0] e_q;
  logic        pow_q;   // power sequence active
  logic        sqr_q;   // current multiply is the squaring
  logic [63:0] ma_q, mb_q;
  logic [1:0]  pp_q;
  logic [127:0] prod_q;
  logic [63:0] res_q;
  logic        fault_q, ovalid_q;
  logic [63:0] out_value_q;
  logic        out_fault_q;

  logic [63:0] a_in, b_in, c_in;
  logic [31:0] e_in, e_mag;
  logic [31:0] mx, my;
  logic [63:0] pp;
  logic [63:0] lo_sum;
  logic        lo_cy;
  logic        out_load;

  assign a_in  = s_axis_tdata[63:0];
  assign b_in  = s_axis_tdata[127:64];
  assign c_in  = s_axis_tdata[191:128];
  assign e_in  = s_axis_tdata[223:192];
  assign e_mag = e_in[31] ? (32'd0 - e_in) : e_in;

  // output register frees the sequencer while a result waits
  assign out_load      = (state_q == StDone) && (!ovalid_q || m_axis_tready);
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, out_fault_q, out_value_q};

  // shared 32x32 multiplier, one partial product per cycle
  always_comb begin
    mx = pp_q[0] ? ma_q[63:32] : ma_q[31:0];
    my = pp_q[1] ? mb_q[63:32] : mb_q[31:0];
    pp = {32'd0, mx} * {32'd0, my};
  end

  assign {lo_cy, lo_sum} = {1'b0, prod_q[63:0]} + {1'b0, c_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      pow_q    <= 1'b0;
      sqr_q    <= 1'b0;
      pp_q     <= '0;
    end else begin
      if (out_load) begin
        out_value_q <= res_q;
        out_fault_q <= fault_q;
        ovalid_q    <= 1'b1;
      end else if (ovalid_q && m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind_q <= s_axis_tuser;
            case (s_axis_tuser)
              gfa_pkg::KindAdd: begin
                logic [64:0] z;
                z = {1'b0, a_in} + {1'b0, b_in};
                res_q <= (z[64] || z[63:0] >= gfa_pkg::FieldP) ?
                         (z[63:0] - gfa_pkg::FieldP) : z[63:0];
                fault_q <= 1'b0;
                state_q <= StDone;
              end
              gfa_pkg::KindSub: begin
                res_q   <= gfa_pkg::f_sub(a_in, b_in);
                fault_q <= 1'b0;
                state_q <= StDone;
              end
              gfa_pkg::KindNeg: begin
                res_q   <= (a_in == 64'd0) ? 64'd0 : (gfa_pkg::FieldP - a_in);
                fault_q <= 1'b0;
                state_q <= StDone;
              end
              gfa_pkg::KindMulAdd: begin
                ma_q <= a_in; mb_q <= b_in; c_q <= c_in;
                pp_q <= '0; prod_q <= '0;
                fault_q <= 1'b0;
                state_q <= StMul;
              end
              gfa_pkg::KindDiv: begin
                if (b_in == 64'd0 || b_in == gfa_pkg::FieldP) begin
                  res_q   <= '0;
                  fault_q <= 1'b1;
                  state_q <= StDone;
                end else begin
                  fault_q <= 1'b0;
                  x_q <= a_in; y_q <= '0; u_q <= b_in; v_q <= gfa_pkg::FieldP;
                  state_q <= StDivOdd;
                end
              end
              gfa_pkg::KindPow: begin
                e_q   <= e_mag;
                acc_q <= 64'd1;
                sq_q  <= a_in;
                if (e_in == 32'd0) begin
                  res_q   <= 64'd1;
                  fault_q <= 1'b0;
                  state_q <= StDone;
                end else if (e_in[31]) begin
                  if (a_in == 64'd0 || a_in == gfa_pkg::FieldP) begin
                    res_q   <= '0;
                    fault_q <= 1'b1;
                    state_q <= StDone;
                  end else begin
                    fault_q <= 1'b0;
                    pow_q <= 1'b1;
                    x_q <= 64'd1; y_q <= '0; u_q <= a_in; v_q <= gfa_pkg::FieldP;
                    state_q <= StDivOdd;
                  end
                end else begin
                  fault_q <= 1'b0;
                  pow_q   <= 1'b1;
                  state_q <= StPowStep;
                end
              end
              default: begin
                res_q   <= '0;
                fault_q <= 1'b0;
                state_q <= StDone;
              end
            endcase
          end
        end
        // strip factors of two, one bit per cycle, from u before v
        StDivOdd: begin
          if (u_q == 64'd1 || v_q == 64'd1) begin
            if (pow_q) begin
              sq_q    <= (u_q == 64'd1) ? x_q : y_q;
              state_q <= StPowStep;
            end else begin
              res_q   <= (u_q == 64'd1) ? x_q : y_q;
              state_q <= StDone;
            end
          end else if (u_q == 64'd0 || v_q == 64'd0) begin
            if (pow_q) begin
              sq_q <= '0; state_q <= StPowStep;
            end else begin
              res_q <= '0; state_q <= StDone;
            end
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
            x_q <= x_q[0] ? ((x_q >> 1) + gfa_pkg::HalfPUp) : (x_q >> 1);
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
            y_q <= y_q[0] ? ((y_q >> 1) + gfa_pkg::HalfPUp) : (y_q >> 1);
          end else begin
            state_q <= StDivSub;
          end
        end
        StDivSub: begin
          if (u_q < v_q) begin
            v_q <= v_q - u_q;
            y_q <= gfa_pkg::f_sub(y_q, x_q);
          end else begin
            u_q <= u_q - v_q;
            x_q <= gfa_pkg::f_sub(x_q, y_q);
          end
          state_q <= StDivOdd;
        end
        // accumulate four partial products
        StMul: begin
          prod_q <= prod_q + ({64'd0, pp} << ({5'd0, pp_q[0]} * 7'd32 + {5'd0, pp_q[1]} * 7'd32));
          pp_q   <= pp_q + 2'd1;
          if (pp_q == 2'd3) state_q <= StMulFold;
        end
        StMulFold: begin
          logic [63:0] r;
          r = gfa_pkg::f_fold(prod_q[127:64] + {63'd0, lo_cy}, lo_sum);
          if (pow_q) begin
            if (sqr_q) begin
              sq_q <= r;
              e_q  <= e_q >> 1;
            end else begin
              // low exponent bit consumed, squaring follows if bits remain
              acc_q <= r;
              e_q   <= {e_q[31:1], 1'b0};
            end
            state_q <= StPowStep;
          end else begin
            res_q   <= r;
            state_q <= StDone;
          end
        end
        // square-and-multiply sequencer
        StPowStep: begin
          c_q <= '0; pp_q <= '0; prod_q <= '0;
          if (e_q == 32'd0) begin
            res_q   <= acc_q;
            pow_q   <= 1'b0;
            state_q <= StDone;
          end else if (e_q[0]) begin
            // set low bit: multiply the accumulator first
            ma_q <= acc_q; mb_q <= sq_q;
            sqr_q <= 1'b0;
            state_q <= StMul;
          end else begin
            ma_q <= sq_q; mb_q <= sq_q;
            sqr_q <= 1'b1;
            state_q <= StMul;
          end
        end
        StDone: begin
          if (out_load) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // checks
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == StIdle)
    else $error("ready outside idle");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |=> m_axis_tvalid)
    else $error("result not presented");
  a_fault_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && fault_q) |->
      (kind_q == gfa_pkg::KindDiv || kind_q == gfa_pkg::KindPow))
    else $error("fault on plain op");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed while stalled");

endmodule
